[hdl/ffea_pkg.sv]
// Package for the first-fit extent allocator: transaction payloads, cell
// control structs, status codes and sequencer states. No dependencies.
package ffea_pkg;

    localparam logic [31:0] ROUND_ADD  = 32'h0000_0fff;
    localparam logic [31:0] ROUND_MASK = 32'hffff_f000;
    localparam logic [31:0] SAT32      = 32'hffff_ffff;
    localparam int unsigned OUT_CNT_W  = 9;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FIT  = 2'd1,
        ST_LOST    = 2'd2,
        ST_UNUSED  = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } seq_state_t;

    typedef struct packed {
        logic        opcode;
        logic [31:0] base_addr;
        logic [31:0] length;
        logic        round_4k;
    } req_t;

    typedef struct packed {
        logic [31:0]          granted_addr;
        logic [1:0]           status;
        logic [31:0]          free_total;
        logic [OUT_CNT_W-1:0] entry_count;
        logic [OUT_CNT_W-1:0] peak_count;
        logic [31:0]          lost_count;
        logic [31:0]          lost_bytes;
    } rsp_t;

    // Broadcast to every cell during the execute cycle.
    typedef struct packed {
        logic        alloc_go;
        logic        free_go;
        logic [31:0] addr;
        logic [31:0] size;
    } cell_cmd_t;

    // Global decisions, gathered from all cells and fed back.
    typedef struct packed {
        logic merge_prev;
        logic merge_next;
        logic remove;
        logic insert;
    } cell_dec_t;

    // Per-cell flags reported to the top level.
    typedef struct packed {
        logic        prev_match;
        logic        next_match;
        logic        hit_empty;
        logic [31:0] granted;
    } cell_stat_t;

endpackage

[hdl/ffea_req_if.sv]
// Request channel of the extent allocator: valid/ready plus request payload.
// Depends on ffea_pkg.
interface ffea_req_if;
    logic            valid;
    logic            ready;
    ffea_pkg::req_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hdl/ffea_rsp_if.sv]
// Response channel of the extent allocator: valid/ready plus result payload.
// Depends on ffea_pkg.
interface ffea_rsp_if;
    logic            valid;
    logic            ready;
    ffea_pkg::rsp_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hdl/ffea_cell.sv]
// One slot of the sorted extent table: holds a base and a length, compares
// against the broadcast request and shifts with its neighbors. Uses ffea_pkg.
module ffea_cell #(
    parameter int unsigned IDX = 0,
    parameter int unsigned CW  = 9
) (
    input  logic                 clk,
    input  ffea_pkg::cell_cmd_t  cmd,
    input  ffea_pkg::cell_dec_t  dec,
    input  logic [CW-1:0]        count,
    input  logic                 left_le,
    input  logic                 left_fit_incl,
    input  logic [31:0]          left_base,
    input  logic [31:0]          left_len,
    input  logic                 right_le,
    input  logic [31:0]          right_base,
    input  logic [31:0]          right_len,
    output logic                 le,
    output logic                 fit_incl,
    output logic [31:0]          base,
    output logic [31:0]          len,
    output ffea_pkg::cell_stat_t stat
);

    logic [31:0] base_reg, base_next;
    logic [31:0] len_reg, len_next;
    logic        valid;
    logic        fit;
    logic        hit;
    logic        is_prev;
    logic        is_next;
    logic        slot;

    assign valid    = CW'(IDX) < count;
    // stop the run at the first higher base, even if the table is out of order
    assign le       = left_le && valid && (base_reg <= cmd.addr);
    assign fit      = valid && (len_reg >= cmd.size);
    assign hit      = fit && !left_fit_incl;
    assign fit_incl = left_fit_incl || fit;
    assign is_prev  = le && !right_le;
    assign is_next  = valid && !le && left_le;
    assign slot     = !le && left_le;
    assign base     = base_reg;
    assign len      = len_reg;

    assign stat.prev_match = is_prev && ((base_reg + len_reg) == cmd.addr);
    assign stat.next_match = is_next && ((cmd.addr + cmd.size) == base_reg);
    assign stat.hit_empty  = hit && (len_reg == cmd.size);
    assign stat.granted    = hit ? base_reg : 32'h0;

    always_comb
    begin
        base_next = base_reg;
        len_next  = len_reg;
        if (cmd.alloc_go)
        begin
            if (dec.remove && fit_incl)
            begin
                base_next = right_base;
                len_next  = right_len;
            end
            else if (hit)
            begin
                base_next = base_reg + cmd.size;
                len_next  = len_reg - cmd.size;
            end
        end
        else if (cmd.free_go)
        begin
            if (dec.merge_prev)
            begin
                if (is_prev)
                begin
                    len_next = len_reg + cmd.size + (dec.merge_next ? right_len : 32'h0);
                end
                else if (dec.merge_next && !le)
                begin
                    // close the gap left by the absorbed next extent
                    base_next = right_base;
                    len_next  = right_len;
                end
            end
            else if (dec.merge_next)
            begin
                if (is_next)
                begin
                    base_next = cmd.addr;
                    len_next  = len_reg + cmd.size;
                end
            end
            else if (dec.insert)
            begin
                if (slot)
                begin
                    base_next = cmd.addr;
                    len_next  = cmd.size;
                end
                else if (!le)
                begin
                    base_next = left_base;
                    len_next  = left_len;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        len_reg  <= len_next;
    end

endmodule

[hdl/first_fit_extent_allocator_unit.sv]
// Top level of the first-fit extent allocator: request sequencer, chain of
// table cells and result register. Uses ffea_pkg, ffea_req_if, ffea_rsp_if.
//
//  channel | direction | payload
//  --------+-----------+-------------------------------------------------
//  req     | in        | opcode, base_addr, length, round_4k
//  rsp     | out       | granted_addr, status, free_total, entry_count,
//          |           | peak_count, lost_count, lost_bytes
//
// Each transaction first registers and rounds the request; then all cells
// compare in parallel and the table shifts by at most one slot.
// The execute cycle waits while an earlier result is still held in rsp.
// Reset clears the counters and the sequencer; table slots are never read
// past the entry count, so they need no clearing.
module first_fit_extent_allocator_unit #(
    parameter int unsigned TABLE_ENTRIES = 256
) (
    input  logic clk,
    input  logic rst_n,
    ffea_req_if.sink   req,
    ffea_rsp_if.source rsp
);

    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned N  = TABLE_ENTRIES;

    ffea_pkg::seq_state_t state_reg, state_next;
    ffea_pkg::req_t       req_reg;
    ffea_pkg::rsp_t       rsp_reg, rsp_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        peak_reg, peak_next;
    logic [31:0]          sum_reg, sum_next;
    logic [31:0]          lost_cnt_reg, lost_cnt_next;
    logic [31:0]          lost_bytes_reg, lost_bytes_next;

    logic                 exec_go;
    logic [31:0]          size_eff;
    logic [32:0]          lost_sum;
    ffea_pkg::cell_cmd_t  cmd;
    ffea_pkg::cell_dec_t  dec;
    ffea_pkg::cell_stat_t stat [N];
    logic [N-1:0]         le_v;
    logic [N-1:0]         fit_v;
    logic [N-1:0]         prev_v;
    logic [31:0]          base_v [N];
    logic [31:0]          len_v  [N];
    logic                 any_prev;
    logic                 any_next;
    logic                 any_empty;
    logic [31:0]          granted;
    logic                 any_fit;
    logic                 table_full;

    // ---------------- sequencer ----------------
    assign req.ready = (state_reg == ffea_pkg::S_IDLE);
    assign exec_go   = (state_reg == ffea_pkg::S_EXEC) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffea_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ffea_pkg::S_EXEC;
                end
            end
            ffea_pkg::S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = ffea_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffea_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        size_eff = req.payload.length;
        if (req.payload.round_4k)
        begin
            size_eff = (req.payload.length + ffea_pkg::ROUND_ADD) & ffea_pkg::ROUND_MASK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_reg <= {req.payload.opcode, req.payload.base_addr, size_eff,
                        req.payload.round_4k};
        end
    end

    // ---------------- cell chain ----------------
    always_comb
    begin
        cmd.alloc_go = exec_go && (req_reg.opcode == ffea_pkg::OP_ALLOC);
        cmd.free_go  = exec_go && (req_reg.opcode == ffea_pkg::OP_FREE);
        cmd.addr     = req_reg.base_addr;
        cmd.size     = req_reg.length;
    end

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_cell
            logic        l_le, l_fit, r_le;
            logic [31:0] l_base, l_len, r_base, r_len;
            if (k == 0)
            begin : g_first
                assign l_le   = 1'b1;
                assign l_fit  = 1'b0;
                assign l_base = 32'h0;
                assign l_len  = 32'h0;
            end
            else
            begin : g_mid_l
                assign l_le   = le_v[k-1];
                assign l_fit  = fit_v[k-1];
                assign l_base = base_v[k-1];
                assign l_len  = len_v[k-1];
            end
            if (k == N - 1)
            begin : g_last
                assign r_le   = 1'b0;
                assign r_base = 32'h0;
                assign r_len  = 32'h0;
            end
            else
            begin : g_mid_r
                assign r_le   = le_v[k+1];
                assign r_base = base_v[k+1];
                assign r_len  = len_v[k+1];
            end

            ffea_cell #(
                .IDX (k),
                .CW  (CW)
            ) u_cell (
                .clk           (clk),
                .cmd           (cmd),
                .dec           (dec),
                .count         (count_reg),
                .left_le       (l_le),
                .left_fit_incl (l_fit),
                .left_base     (l_base),
                .left_len      (l_len),
                .right_le      (r_le),
                .right_base    (r_base),
                .right_len     (r_len),
                .le            (le_v[k]),
                .fit_incl      (fit_v[k]),
                .base          (base_v[k]),
                .len           (len_v[k]),
                .stat          (stat[k])
            );
            assign prev_v[k] = stat[k].prev_match;
        end
    endgenerate

    always_comb
    begin
        any_next  = 1'b0;
        any_empty = 1'b0;
        granted   = 32'h0;
        for (int i = 0; i < N; i++)
        begin
            any_next  = any_next | stat[i].next_match;
            any_empty = any_empty | stat[i].hit_empty;
            granted   = granted | stat[i].granted;
        end
    end

    assign any_prev   = |prev_v;
    assign any_fit    = fit_v[N-1];
    assign table_full = (count_reg == CW'(N));

    always_comb
    begin
        dec.merge_prev = any_prev;
        dec.merge_next = any_next;
        dec.remove     = any_empty;
        dec.insert     = !any_prev && !any_next && !table_full;
    end

    // ---------------- bookkeeping ----------------
    assign lost_sum = {1'b0, lost_bytes_reg} + {1'b0, req_reg.length};

    always_comb
    begin
        count_next      = count_reg;
        sum_next        = sum_reg;
        lost_cnt_next   = lost_cnt_reg;
        lost_bytes_next = lost_bytes_reg;
        rsp_next        = rsp_reg;
        rsp_next.granted_addr = 32'h0;
        rsp_next.status       = ffea_pkg::ST_OK;
        if (cmd.alloc_go)
        begin
            if (any_fit)
            begin
                rsp_next.granted_addr = granted;
                sum_next = sum_reg - req_reg.length;
                if (any_empty)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            else
            begin
                rsp_next.status = ffea_pkg::ST_NO_FIT;
            end
        end
        else if (cmd.free_go)
        begin
            if (any_prev || any_next || !table_full)
            begin
                sum_next = sum_reg + req_reg.length;
                if (any_prev && any_next)
                begin
                    count_next = count_reg - CW'(1);
                end
                else if (!any_prev && !any_next)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            else
            begin
                rsp_next.status = ffea_pkg::ST_LOST;
                if (lost_cnt_reg != ffea_pkg::SAT32)
                begin
                    lost_cnt_next = lost_cnt_reg + 32'd1;
                end
                lost_bytes_next = lost_sum[32] ? ffea_pkg::SAT32 : lost_sum[31:0];
            end
        end
        peak_next = (count_next > peak_reg) ? count_next : peak_reg;
        rsp_next.free_total  = sum_next;
        rsp_next.entry_count = ffea_pkg::OUT_CNT_W'(count_next);
        rsp_next.peak_count  = ffea_pkg::OUT_CNT_W'(peak_next);
        rsp_next.lost_count  = lost_cnt_next;
        rsp_next.lost_bytes  = lost_bytes_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ffea_pkg::S_IDLE;
            out_valid_reg  <= 1'b0;
            count_reg      <= '0;
            peak_reg       <= '0;
            sum_reg        <= 32'h0;
            lost_cnt_reg   <= 32'h0;
            lost_bytes_reg <= 32'h0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            if (exec_go)
            begin
                count_reg      <= count_next;
                peak_reg       <= peak_next;
                sum_reg        <= sum_next;
                lost_cnt_reg   <= lost_cnt_next;
                lost_bytes_reg <= lost_bytes_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = rsp_reg;

    // ---------------- checks ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(N))
        else $error("entry count above table size");

    a_peak_cover: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= count_reg)
        else $error("peak below current entry count");

    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        exec_go |=> out_valid_reg)
        else $error("executed transaction left no result");

    a_one_prev: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(prev_v))
        else $error("more than one predecessor extent matched");

endmodule
